>>> design/icc_pkg.sv
// Shared types, constants and helper functions for the IUPAC column consensus block.
// Used by icc_front, icc_queue, icc_back, icc_checker and the top level; depends on nothing.
package icc_pkg;

  localparam int unsigned MAX_SEQUENCES = 1024;
  localparam int          NUM_ALLELES   = 5;
  localparam int          CNT_W         = $clog2(MAX_SEQUENCES + 1);
  localparam int          IDX_W         = $clog2(NUM_ALLELES + 1);
  localparam int          LFSR_W        = 32;
  localparam int          QUEUE_DEPTH   = 2;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  // ASCII codes
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_N = 8'h4E;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_U = 8'h55;
  localparam logic [7:0] CH_V = 8'h56;
  localparam logic [7:0] CH_W = 8'h57;
  localparam logic [7:0] CH_Y = 8'h59;
  localparam logic [7:0] CH_LC_A = 8'h61;
  localparam logic [7:0] CH_LC_Z = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef logic [NUM_ALLELES-1:0] allele_mask_t;   // bit0 A .. bit4 U
  typedef logic [CNT_W-1:0]       count_t;
  typedef count_t [NUM_ALLELES-1:0] counts_t;

  // Alleles an IUPAC byte stands for, case folded
  function automatic allele_mask_t code_mask(input logic [7:0] b);
    logic [7:0]   u;
    allele_mask_t m;
    u = b;
    if (b >= CH_LC_A && b <= CH_LC_Z) begin
      u = b - CASE_GAP;
    end
    unique case (u)
      CH_A:    m = 5'b00001;
      CH_C:    m = 5'b00010;
      CH_G:    m = 5'b00100;
      CH_T:    m = 5'b01000;
      CH_U:    m = 5'b10000;
      CH_M:    m = 5'b00011;
      CH_R:    m = 5'b00101;
      CH_W:    m = 5'b01001;
      CH_S:    m = 5'b00110;
      CH_Y:    m = 5'b01010;
      CH_K:    m = 5'b01100;
      CH_V:    m = 5'b00111;
      CH_H:    m = 5'b01011;
      CH_D:    m = 5'b01101;
      CH_B:    m = 5'b01110;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] allele_char(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = CH_A;
      3'd1:    c = CH_C;
      3'd2:    c = CH_G;
      3'd3:    c = CH_T;
      3'd4:    c = CH_U;
      default: c = CH_N;
    endcase
    return c;
  endfunction

endpackage

>>> design/iupac_column_consensus_top.sv
// IUPAC column consensus, top level: front end, count queue and back end.
// Depends on icc_pkg, icc_front, icc_queue and icc_back.
//
// Usage
//   Input stream: one word per base of an alignment column, base in s_tdata,
//   s_tlast high on the column's last base. Upper and lower case IUPAC codes
//   count towards every allele they stand for (A C G T U); anything else is
//   ignored. Counts saturate at MAX_SEQUENCES.
//   Output stream: one word per column, the consensus base in m_tdata (N when
//   nothing counted) and m_tuser[0] set when the call was a random tie break.
//   cfg_we/cfg_wdata reload the tie LFSR seed; write only while the block is
//   idle. A zero seed loads 1.
// Throughput and sequencing
//   Bases are taken at one per cycle while s_tready is high. Each column end
//   takes the back end through its load, max search, tie draw (with a 32x3
//   multiply) and select states, and it takes no new column until it is back
//   at load; a two-entry count queue lets the front keep counting the next
//   column meanwhile.
// Reset and stalls
//   rst (synchronous) clears the counts, empties the queue, drops m_tvalid and
//   loads the LFSR with 1. When the receiver holds m_tready low the result word
//   stays put; s_tready falls only once the queue holds two finished columns.
module iupac_column_consensus_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,     // tie_seed
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [7:0] base
  input  logic        s_tlast,       // column_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,       // [7:0] consensus_base
  output logic [0:0]  m_tuser        // [0] was_tie
);
  import icc_pkg::*;

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  counts_t push_counts;
  counts_t pop_counts;

  icc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .q_full      (q_full),
    .push        (push),
    .push_counts (push_counts)
  );

  icc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_counts),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_counts),
    .empty     (q_empty)
  );

  icc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_empty   (q_empty),
    .q_data    (pop_counts),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

>>> design/icc_front.sv
// Front end: takes bases, folds case, decodes IUPAC codes and keeps the running allele counts.
// Pushes a snapshot of the counts on each column end. Depends on icc_pkg.
module icc_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic             q_full,
  output logic             push,
  output icc_pkg::counts_t push_counts
);
  import icc_pkg::*;

  counts_t      counts;
  counts_t      counts_next;
  allele_mask_t mask;
  logic         accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    mask = code_mask(s_tdata);
    for (int i = 0; i < NUM_ALLELES; i++) begin
      if (mask[i] && counts[i] < count_t'(MAX_SEQUENCES)) begin
        counts_next[i] = counts[i] + count_t'(1);
      end else begin
        counts_next[i] = counts[i];
      end
    end
  end

  assign push        = accept && s_tlast;
  assign push_counts = counts_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts <= '0;
    end else if (accept) begin
      counts <= s_tlast ? '0 : counts_next;
    end
  end

endmodule

>>> design/icc_queue.sv
// Short queue of finished column counts between front and back end.
// Depends on icc_pkg for the entry type and depth.
module icc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  icc_pkg::counts_t push_data,
  output logic             full,
  input  logic             pop,
  output icc_pkg::counts_t pop_data,
  output logic             empty
);
  import icc_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  counts_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;

  assign full     = fill == FILL_W'(QUEUE_DEPTH);
  assign empty    = fill == '0;
  assign pop_data = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

endmodule

>>> design/icc_back.sv
// Back end: finds the top count, breaks ties with the LFSR and holds the result word.
// Four-state sequencer fed from icc_queue. Depends on icc_pkg.
module icc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic             q_empty,
  input  icc_pkg::counts_t q_data,
  output logic             pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic [0:0]       m_tuser
);
  import icc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_PICK = 2'd2;
  localparam logic [1:0] ST_SEL  = 2'd3;
  localparam int         PROD_W  = LFSR_W + IDX_W;

  logic [1:0]        state;
  counts_t           cnt;
  allele_mask_t      tie_mask;
  logic [IDX_W-1:0]  tied;
  logic [IDX_W-1:0]  pick;
  logic              was_tie;
  logic [LFSR_W-1:0] lfsr;
  logic              out_valid;
  logic [7:0]        out_data;
  logic              out_tie;

  count_t            best;
  allele_mask_t      eq_mask;
  logic [IDX_W-1:0]  tied_n;
  logic [LFSR_W-1:0] lfsr_step;
  logic [PROD_W-1:0] product;
  logic [IDX_W-1:0]  seen;
  logic [7:0]        sel_char;
  logic              out_free;

  // max over the five counters, then the set of alleles at that max
  always_comb begin
    best = '0;
    for (int i = 0; i < NUM_ALLELES; i++) begin
      if (cnt[i] > best) begin
        best = cnt[i];
      end
    end
    for (int i = 0; i < NUM_ALLELES; i++) begin
      eq_mask[i] = (cnt[i] == best) && (best != '0);
    end
    tied_n = IDX_W'($countones(eq_mask));
  end

  assign lfsr_step = {1'b0, lfsr[LFSR_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
  assign product   = PROD_W'(lfsr_step) * PROD_W'(tied);

  // pick-th set bit of the tie mask, in allele order
  always_comb begin
    sel_char = CH_N;
    seen     = '0;
    for (int i = 0; i < NUM_ALLELES; i++) begin
      if (tie_mask[i]) begin
        if (seen == pick) begin
          sel_char = allele_char(IDX_W'(i));
        end
        seen = seen + IDX_W'(1);
      end
    end
  end

  assign out_free = !out_valid || m_tready;
  assign pop      = (state == ST_IDLE) && !q_empty;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_tie;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lfsr      <= LFSR_W'(1);
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state <= ST_PICK;
        end
        ST_PICK: begin
          state <= ST_SEL;
        end
        ST_SEL: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // a new word replaces the one taken in the same cycle
      if ((state == ST_SEL) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      // seed reload; zero seed would lock the LFSR
      if (cfg_we) begin
        lfsr <= (cfg_wdata != '0) ? cfg_wdata : LFSR_W'(1);
      end else if ((state == ST_PICK) && (tied > IDX_W'(1))) begin
        lfsr <= lfsr_step;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          cnt <= q_data;
        end
      end
      ST_EVAL: begin
        tie_mask <= eq_mask;
        tied     <= tied_n;
      end
      ST_PICK: begin
        if (tied > IDX_W'(1)) begin
          pick    <= product[PROD_W-1:LFSR_W];
          was_tie <= 1'b1;
        end else begin
          pick    <= '0;
          was_tie <= 1'b0;
        end
      end
      ST_SEL: begin
        if (out_free) begin
          out_data <= sel_char;
          out_tie  <= was_tie;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/icc_checker.sv
// Port-level checks for the IUPAC column consensus top level, bound onto it.
// Depends on icc_pkg for the ASCII codes.
module icc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [0:0]  m_tuser
);
  import icc_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  a_legal_call: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == CH_A || m_tdata == CH_C || m_tdata == CH_G ||
                  m_tdata == CH_T || m_tdata == CH_U || m_tdata == CH_N))
    else $error("consensus base not an allele or N");

  a_tie_not_n: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata != CH_N)
    else $error("tie flagged on an empty column");

endmodule

bind iupac_column_consensus_top icc_checker u_icc_checker (.*);

>>> tb/sv/iupac_column_consensus_top_tb.sv
// Self-checking testbench for iupac_column_consensus_top: streams alignment columns
// in, predicts each consensus call and compares every output word against it.
// Depends on icc_pkg and the iupac_column_consensus_top RTL.
module iupac_column_consensus_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import icc_pkg::*;

  // Bytes the block must ignore, beyond N and random noise
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_HIGH  = 8'hFF;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [7:0] CALL_CHARS [NUM_ALLELES] = '{CH_A, CH_C, CH_G, CH_T, CH_U};
  localparam logic [7:0] IUPAC_CODES [15] = '{CH_A, CH_C, CH_G, CH_T, CH_U, CH_M, CH_R,
                                               CH_W, CH_S, CH_Y, CH_K, CH_V, CH_H, CH_D,
                                               CH_B};

  localparam int DRAIN_CYCLES = 12;   // back end sequence, output register, margin

  typedef struct packed {
    logic [7:0] base;
    logic       tie;
  } call_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic [0:0]  m_tuser;

  // Predictor state: running allele tallies and the tie-break LFSR
  int unsigned allele_cnt [NUM_ALLELES];
  logic [31:0] tie_state;

  call_t       pending_calls [$];   // consensus calls still owed by the block
  logic [7:0]  column_q [$];        // bases of the column about to be sent
  int          errors;
  bit          quiet;               // no idling on either side
  int          hold_cycles;         // long receiver hold-off, counted by the receiver

  iupac_column_consensus_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Alleles a byte stands for after case folding, bit 0 A .. bit 4 U
  function automatic logic [NUM_ALLELES-1:0] alleles_of(input logic [7:0] b);
    logic [7:0] u;
    u = (b >= CH_LC_A && b <= CH_LC_Z) ? b - CASE_BIT : b;
    case (u)
      CH_A:    return 5'b00001;
      CH_C:    return 5'b00010;
      CH_G:    return 5'b00100;
      CH_T:    return 5'b01000;
      CH_U:    return 5'b10000;
      CH_M:    return 5'b00011;
      CH_R:    return 5'b00101;
      CH_W:    return 5'b01001;
      CH_S:    return 5'b00110;
      CH_Y:    return 5'b01010;
      CH_K:    return 5'b01100;
      CH_V:    return 5'b00111;
      CH_H:    return 5'b01011;
      CH_D:    return 5'b01101;
      CH_B:    return 5'b01110;
      default: return '0;
    endcase
  endfunction

  // Count one accepted base; on a column end, queue the expected call and clear
  function automatic void tally_base(input logic [7:0] b, input logic last);
    logic [NUM_ALLELES-1:0] hits;
    int unsigned            best;
    int unsigned            tied;
    int unsigned            seen;
    int unsigned            pick;
    logic                   lsb;
    call_t                  c;
    hits = alleles_of(b);
    for (int i = 0; i < NUM_ALLELES; i++) begin
      if (hits[i] && allele_cnt[i] < MAX_SEQUENCES) allele_cnt[i]++;
    end
    if (!last) return;
    best = 0;
    tied = 0;
    for (int i = 0; i < NUM_ALLELES; i++) begin
      if (allele_cnt[i] > best) best = allele_cnt[i];
    end
    c.base = CH_N;
    c.tie  = 1'b0;
    if (best != 0) begin
      for (int i = 0; i < NUM_ALLELES; i++) begin
        if (allele_cnt[i] == best) tied++;
      end
      if (tied == 1) begin
        for (int i = 0; i < NUM_ALLELES; i++) begin
          if (allele_cnt[i] == best) c.base = CALL_CHARS[i];
        end
      end else begin
        // LFSR steps before the draw; pick = (lfsr * k) >> 32 among the tied
        lsb       = tie_state[0];
        tie_state = tie_state >> 1;
        if (lsb) tie_state = tie_state ^ LFSR_TAPS;
        pick = 32'((64'(tie_state) * 64'(tied)) >> 32);
        seen = 0;
        for (int i = 0; i < NUM_ALLELES; i++) begin
          if (allele_cnt[i] == best) begin
            if (seen == pick) c.base = CALL_CHARS[i];
            seen++;
          end
        end
        c.tie = 1'b1;
      end
    end
    pending_calls = {pending_calls, c};
    for (int i = 0; i < NUM_ALLELES; i++) allele_cnt[i] = 0;
  endfunction

  // Mostly IUPAC codes in either case, a quarter raw bytes
  function automatic logic [7:0] random_base();
    case ($urandom_range(0, 7))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return IUPAC_CODES[$urandom_range(0, 14)] | CASE_BIT;
      default: return IUPAC_CODES[$urandom_range(0, 14)];
    endcase
  endfunction

  // Offer one word, with an optional idle burst first; tally it once taken
  task automatic send_base(input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tally_base(b, last);
  endtask

  task automatic send_column();
    foreach (column_q[i]) send_base(column_q[i], i == column_q.size() - 1);
    column_q.delete();
  endtask

  // Sender pauses until every call has come back, then lets the back end settle
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_calls.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] seed);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tie_state = (seed != 0) ? seed : 32'd1;
  endtask

  // Every code, both cases, ignored bytes, empty columns and ties, on the reset seed
  task automatic test_directed_codes();
    column_q = '{CH_A};
    send_column();
    column_q = '{CH_C | CASE_BIT, CH_G};
    send_column();
    column_q = '{CH_U, CH_U | CASE_BIT, CH_T | CASE_BIT};
    send_column();
    column_q = '{CH_DASH, CH_N};
    send_column();
    column_q = '{CH_NUL, CH_HIGH, CH_X, CH_ZERO, CH_N | CASE_BIT};
    send_column();
    // ten ambiguity codes, six hits on each of A C G T: four-way tie
    column_q = '{CH_M, CH_R, CH_W, CH_S, CH_Y, CH_K, CH_V, CH_H, CH_D, CH_B};
    send_column();
    column_q = '{CH_Y | CASE_BIT};
    send_column();
    wait_idle();
  endtask

  // A and C both pinned at MAX_SEQUENCES, so the extra A must still leave a tie
  task automatic test_saturation();
    for (int i = 0; i < MAX_SEQUENCES + 6; i++) column_q = {column_q, CH_M};
    column_q = {column_q, CH_A};
    send_column();
    wait_idle();
  endtask

  // Receiver holds off long enough for the queue to fill and s_tready to drop
  task automatic test_backpressure();
    hold_cycles = 400;
    for (int n = 0; n < 40; n++) begin
      repeat ($urandom_range(1, 2)) column_q = {column_q, random_base()};
      send_column();
    end
    wait_idle();
  endtask

  // Random columns; a quarter drawn from two alleles so ties come often
  task automatic test_random(input int n_items);
    int         sent;
    int         len;
    bit         pair_mode;
    logic [7:0] pair_a;
    logic [7:0] pair_b;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      pair_mode = ($urandom_range(0, 3) == 0);
      pair_a    = CALL_CHARS[$urandom_range(0, NUM_ALLELES - 1)];
      pair_b    = CALL_CHARS[$urandom_range(0, NUM_ALLELES - 1)];
      len       = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
      for (int j = 0; j < len; j++) begin
        if (pair_mode) begin
          b = $urandom_range(0, 1) ? pair_a : pair_b;
          if ($urandom_range(0, 1)) b = b | CASE_BIT;
        end else begin
          b = random_base();
        end
        column_q = {column_q, b};
      end
      sent += len;
      send_column();
    end
    wait_idle();
  endtask

  // Seed register at its extremes, the zero-seed fallback and a random value
  task automatic test_seed_sweep();
    write_seed(32'h0000_0000);
    test_random(85);
    write_seed(32'hFFFF_FFFF);
    test_random(85);
    write_seed(32'h8000_0000);
    test_random(85);
    write_seed($urandom_range(2, 32'hFFFF_FFFE));
    test_random(85);
    write_seed(32'h0000_0001);
  endtask

  // Receiver: random stall bursts, one long hold on request, none when quiet
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Each output word against the oldest owed call, field by field
  always @(posedge clk) begin : check_calls
    call_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_calls.size() == 0) begin
        $display("%0t: unexpected word, got base %h tie %b", $time, m_tdata, m_tuser[0]);
        errors++;
      end else begin
        want = pending_calls.pop_front();
        if (m_tdata !== want.base) begin
          $display("%0t: consensus_base expected %h got %h", $time, want.base, m_tdata);
          errors++;
        end
        if (m_tuser[0] !== want.tie) begin
          $display("%0t: was_tie expected %b got %b", $time, want.tie, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    errors      = 0;
    quiet       = 1'b0;
    hold_cycles = 0;
    tie_state   = 32'd1;
    for (int i = 0; i < NUM_ALLELES; i++) allele_cnt[i] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_codes();
    test_saturation();
    test_backpressure();
    test_seed_sweep();
    quiet = 1'b1;
    test_random(400);

    if (errors == 0 && pending_calls.size() == 0) begin
      $display("PASS iupac_column_consensus_top");
    end else begin
      $display("FAIL iupac_column_consensus_top");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("FAIL iupac_column_consensus_top");
    $finish;
  end

endmodule
